// ===== design/ask_power_frame_modulator_top_macros.svh =====
// ----------------------------------------------------------------------------
// ASK power frame modulator assertion macros
// Shared assertion forms for the checker of the modulator top level.
// ----------------------------------------------------------------------------
`ifndef ASK_POWER_FRAME_MODULATOR_TOP_MACROS_SVH
`define ASK_POWER_FRAME_MODULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASPFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASPFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/aspfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator package
// Types, register indexes and half-bit step codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package aspfm_pkg;

    localparam int SAMPLE_BITS = 17;
    localparam int CODE_BITS   = 8;
    localparam int WORD_BITS   = 10;
    localparam int STEP_BITS   = 6;
    localparam int DIV_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_power_sample;
    typedef logic [WORD_BITS-1:0]          t_frame_word;
    typedef logic [STEP_BITS-1:0]          t_step;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_index;
    typedef logic [DIV_BITS-1:0]           t_cfg_data;

    // register indexes
    localparam t_cfg_index CFG_ENABLE        = 2'd0;
    localparam t_cfg_index CFG_TICK_DIVIDER  = 2'd1;
    localparam t_cfg_index CFG_POWER_REQUEST = 2'd2;

    localparam t_cfg_data TICK_DIVIDER_RESET = 16'd2;

    // half-bit sequencer steps
    localparam t_step STEP_FRAME_START = 6'd0;
    localparam t_step STEP_LEAD        = 6'd1;
    localparam t_step STEP_STOP_LOW    = 6'd22;
    localparam t_step STEP_STOP_END    = 6'd23;
    localparam t_step STEP_LAST        = 6'd39;

    typedef struct packed {
        logic       valid;
        t_cfg_index index;
        t_cfg_data  data;
    } t_cfg_wr;

    typedef struct packed {
        logic ask_level;
        logic frame_start;
    } t_seq_result;

endpackage

`default_nettype wire

// ===== design/aspfm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator configuration channel
// Register write transfers: index and data under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspfm_cfg_if;
    import aspfm_pkg::*;

    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/aspfm_in_if.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator tick channel
// One transfer per tick, carrying a power sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspfm_in_if;
    import aspfm_pkg::*;

    logic          valid;
    logic          ready;
    t_power_sample power_sample;

    modport source (output valid, output power_sample, input ready);
    modport sink   (input valid, input power_sample, output ready);
endinterface

`default_nettype wire

// ===== design/aspfm_out_if.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator result channel
// One transfer per tick: line level and frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspfm_out_if;
    logic valid;
    logic ready;
    logic ask_level;
    logic frame_start;

    modport source (output valid, output ask_level, output frame_start, input ready);
    modport sink   (input valid, input ask_level, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== design/aspfm_word.sv =====
// ----------------------------------------------------------------------------
// ASK power frame word builder
// Clamp the sample, scale it to an 8-bit code and add request and parity bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aspfm_word #(
    parameter int MAX_POWER_WATTS = 150
) (
    input  aspfm_pkg::t_power_sample i_sample,
    input  logic                     i_request,
    output aspfm_pkg::t_frame_word   o_word
);
    import aspfm_pkg::*;

    localparam int FULL   = MAX_POWER_WATTS * 256;
    localparam int P_BITS = $clog2(FULL + 1);
    localparam int X_BITS = P_BITS + 8;
    localparam int L_BITS = $clog2(FULL);
    localparam int K_SHIFT = X_BITS + L_BITS;
    localparam int M_BITS = X_BITS + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << K_SHIFT) + 64'(FULL) - 64'd1) / 64'(FULL);
    localparam logic [M_BITS-1:0] RECIP_M = RECIP[M_BITS-1:0];

    logic [15:0]              w_clamp;
    logic [P_BITS-1:0]        w_p;
    logic [X_BITS-1:0]        w_x;
    logic [X_BITS+M_BITS-1:0] w_prod;
    logic [CODE_BITS-1:0]     w_code;

    // clamp to 0 .. full scale
    always_comb begin
        if (i_sample[SAMPLE_BITS-1]) begin
            w_clamp = 16'd0;
        end else if (i_sample[15:0] > 16'(FULL)) begin
            w_clamp = 16'(FULL);
        end else begin
            w_clamp = i_sample[15:0];
        end
    end

    assign w_p = w_clamp[P_BITS-1:0];
    // times 255 as a shift and subtract
    assign w_x = {w_p, 8'd0} - X_BITS'(w_p);
    // exact divide by full scale through a reciprocal
    assign w_prod = (X_BITS+M_BITS)'(w_x) * (X_BITS+M_BITS)'(RECIP_M);
    assign w_code = w_prod[K_SHIFT +: CODE_BITS];

    assign o_word = {^{w_code, i_request}, w_code, i_request};

endmodule

`default_nettype wire

// ===== design/aspfm_seq.sv =====
// ----------------------------------------------------------------------------
// ASK power frame half-bit sequencer
// Configuration registers, tick divider and the 40-step line sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module aspfm_seq #(
    parameter int MAX_POWER_WATTS = 150
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  aspfm_pkg::t_cfg_wr       i_cfg,
    input  logic                     i_step,
    input  aspfm_pkg::t_power_sample i_sample,
    output aspfm_pkg::t_seq_result   o_res
);
    import aspfm_pkg::*;

    logic          r_enable;
    t_cfg_data     r_tick_div;
    logic          r_request;
    logic          r_level, n_level;
    t_step         r_idx, n_idx;
    t_cfg_data     r_cnt, n_cnt;
    t_frame_word   r_word, n_word;
    logic          n_started;

    t_frame_word   w_new_word;
    t_cfg_data     w_div;
    logic [16:0]   w_cnt_inc;
    logic [3:0]    w_bit;
    t_frame_word   w_shift;

    aspfm_word #(
        .MAX_POWER_WATTS(MAX_POWER_WATTS)
    ) u_word (
        .i_sample (i_sample),
        .i_request(r_request),
        .o_word   (w_new_word)
    );

    assign w_div     = (r_tick_div == '0) ? 16'd1 : r_tick_div;
    assign w_cnt_inc = {1'b0, r_cnt} + 17'd1;
    assign w_bit     = r_idx[4:1] - 4'd1;
    assign w_shift   = r_word >> w_bit;

    always_comb begin
        n_level   = r_level;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_started = 1'b0;
        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_ENABLE && !i_cfg.data[0]) begin
                n_level = 1'b0;
                n_idx   = '0;
                n_cnt   = '0;
            end else if (i_cfg.index == CFG_TICK_DIVIDER) begin
                n_idx = '0;
                n_cnt = '0;
            end
        end else if (i_step) begin
            if (!r_enable) begin
                n_level = 1'b0;
                n_idx   = '0;
                n_cnt   = '0;
            end else if (w_cnt_inc < {1'b0, w_div}) begin
                n_cnt = w_cnt_inc[15:0];
            end else begin
                n_cnt = '0;
                n_idx = r_idx + 6'd1;
                case (r_idx)
                    STEP_FRAME_START: begin
                        n_level   = 1'b1;
                        n_word    = w_new_word;
                        n_started = 1'b1;
                    end
                    STEP_LEAD, STEP_STOP_END: begin
                        n_level = r_level;
                    end
                    STEP_STOP_LOW: begin
                        n_level = 1'b0;
                    end
                    STEP_LAST: begin
                        n_level = 1'b0;
                        n_idx   = '0;
                    end
                    default: begin
                        // odd steps carry data (or toggle in the gap), even steps toggle
                        if (!r_idx[0] || r_idx > STEP_STOP_END || w_shift[0]) begin
                            n_level = !r_level;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_tick_div <= TICK_DIVIDER_RESET;
            r_request  <= 1'b0;
            r_level    <= 1'b0;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_word     <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ENABLE:        r_enable   <= i_cfg.data[0];
                    CFG_TICK_DIVIDER:  r_tick_div <= i_cfg.data;
                    CFG_POWER_REQUEST: r_request  <= i_cfg.data[0];
                    default:           r_enable   <= r_enable;
                endcase
            end
            r_level <= n_level;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_word  <= n_word;
        end
    end

    assign o_res.ask_level   = n_level;
    assign o_res.frame_start = n_started;

endmodule

`default_nettype wire

// ===== design/ask_power_frame_modulator_top.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator top level
// Differential bi-phase ASK framing of a power report, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg   register writes (index 0 enable, 1 tick divider, 2 power request),
//           always ready; write only while no tick is in flight.
//   i_in    one transfer per tick, carrying a signed 17-bit power sample
//           (watts, 8 fraction bits).
//   o_out   one transfer per accepted tick: the line level after that tick and
//           a flag that marks the tick that started a frame and latched a word.
// Timing:
//   A tick accepted at i_in is held in the input register, stepped through
//   the sequencer and word builder, and shows on o_out once the result
//   register takes it. One tick is accepted every cycle while o_out is not
//   stalled; the rate is set by the input register feeding the combinational
//   sequencer step and word builder into the result register.
// Reset:
//   Synchronous, active low. The modulator comes up disabled with the line low,
//   tick divider 2 and both pipeline registers empty.
// Stall:
//   While o_out is held off the result register keeps its transfer, the input
//   register still takes one more tick, and i_in.ready then drops until the
//   result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module ask_power_frame_modulator_top #(
    parameter int MAX_POWER_WATTS = 150
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aspfm_cfg_if.sink    i_cfg,
    aspfm_in_if.sink     i_in,
    aspfm_out_if.source  o_out
);
    import aspfm_pkg::*;

    logic          r_in_valid;
    t_power_sample r_sample;
    logic          r_out_valid;
    logic          r_ask_level;
    logic          r_frame_start;

    logic          w_adv;
    t_cfg_wr       w_cfg;
    t_seq_result   w_res;

    // advance the held tick when the result register is free or draining
    assign w_adv = r_in_valid && (!r_out_valid || o_out.ready);

    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign w_cfg.valid = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    aspfm_seq #(
        .MAX_POWER_WATTS(MAX_POWER_WATTS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_adv),
        .i_sample(r_sample),
        .o_res   (w_res)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_sample <= i_in.power_sample;
        end
        if (w_adv) begin
            r_ask_level   <= w_res.ask_level;
            r_frame_start <= w_res.frame_start;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ask_level   = r_ask_level;
    assign o_out.frame_start = r_frame_start;

endmodule

`default_nettype wire

// ===== design/aspfm_checker.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator port checker
// Watch the top-level channels over time; attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ask_power_frame_modulator_top_macros.svh"

module aspfm_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   i_cfg_ready,
    input aspfm_pkg::t_cfg_index  i_cfg_index,
    input aspfm_pkg::t_cfg_data   i_cfg_data,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_out_ask_level,
    input logic                   i_out_frame_start
);
    import aspfm_pkg::*;

    logic r_enable;

    // shadow of the enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && i_cfg_ready && i_cfg_index == CFG_ENABLE) begin
            r_enable <= i_cfg_data[0];
        end
    end

    `ASPFM_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `ASPFM_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_ask_level) && $stable(i_out_frame_start), "result changed while stalled")
    `ASPFM_ASSERT_NOW(a_start_drives_high, i_clk, i_rst_n, i_out_valid && i_out_frame_start, i_out_ask_level, "frame start without high line")
    `ASPFM_ASSERT_NOW(a_disabled_quiet, i_clk, i_rst_n, i_out_valid && !r_enable, !i_out_ask_level && !i_out_frame_start, "activity while disabled")

endmodule

bind ask_power_frame_modulator_top aspfm_checker u_aspfm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_valid      (i_cfg.valid),
    .i_cfg_ready      (i_cfg.ready),
    .i_cfg_index      (i_cfg.index),
    .i_cfg_data       (i_cfg.data),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_ask_level  (o_out.ask_level),
    .i_out_frame_start(o_out.frame_start)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// ASK power frame modulator testbench
// Streams power-sample ticks through the modulator under random source and
// sink stalls. Every accepted tick is run through a cycle-free copy of the
// half-bit sequencer, and the result stream is compared against it, field by
// field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import aspfm_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 4;
    localparam int MAX_POWER_WATTS = 150;
    localparam int FULL_SCALE      = MAX_POWER_WATTS * 256;
    localparam int SETTLE_CYCLES   = 6;       // covers the input and result registers, plus margin
    localparam int LONG_HOLD       = 60;      // sink hold-off that backs up the pipe
    localparam int CYCLE_LIMIT     = 200000;

    // Index 3 is not decoded by the block; writes to it must do nothing.
    localparam t_cfg_index CFG_SPARE = t_cfg_index'(3);

    // Samples around the clamp points and the ends of the 17-bit range.
    localparam int LIMIT_SAMPLES [10] = '{-65536, -1, 0, 1, 150, 19200,
                                          FULL_SCALE - 1, FULL_SCALE,
                                          FULL_SCALE + 1, 65535};

    // ------------------------------------------------------------------------
    // Clock, reset and the signals driven into the block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic          drv_valid  = 1'b0;
    t_power_sample drv_sample = '0;
    logic          cfg_valid  = 1'b0;
    t_cfg_index    cfg_index  = '0;
    t_cfg_data     cfg_data   = '0;
    logic          sink_ready = 1'b0;

    aspfm_cfg_if cfg_if ();
    aspfm_in_if  in_if ();
    aspfm_out_if out_if ();

    assign cfg_if.valid       = cfg_valid;
    assign cfg_if.index       = cfg_index;
    assign cfg_if.data        = cfg_data;
    assign in_if.valid        = drv_valid;
    assign in_if.power_sample = drv_sample;
    assign out_if.ready       = sink_ready;

    ask_power_frame_modulator_top #(
        .MAX_POWER_WATTS(MAX_POWER_WATTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // ------------------------------------------------------------------------
    // Sequencer copy: registers, line state and the word latched at step 0
    // ------------------------------------------------------------------------
    logic        seq_enable  = 1'b0;
    t_cfg_data   seq_divider = TICK_DIVIDER_RESET;
    logic        seq_request = 1'b0;
    logic        seq_line    = 1'b0;
    t_step       seq_step    = STEP_FRAME_START;
    t_cfg_data   seq_wait    = '0;
    t_frame_word seq_word    = '0;

    t_power_sample pending_ticks[$];      // samples waiting to be offered
    t_seq_result   predicted_levels[$];   // line results owed by the block

    int src_idle_pct  = 32;
    int snk_idle_pct  = 53;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    t_seq_result owed;

    // Clamp to 0..full scale, scale to 8 bits with truncation, then pack
    // request, code and an even-parity bit into the ten-bit word.
    function automatic t_frame_word frame_word_of(t_power_sample sample);
        int          watts;
        int          code;
        t_frame_word word;
        watts = sample;
        if (watts < 0) watts = 0;
        if (watts > FULL_SCALE) watts = FULL_SCALE;
        code = (watts * 255) / FULL_SCALE;
        if (code > 255) code = 255;
        word    = {1'b0, code[7:0], seq_request};
        word[9] = ^word[8:0];
        return word;
    endfunction

    // Advance the sequencer by one tick and return the line after it.
    function automatic t_seq_result step_modulator(t_power_sample sample);
        t_seq_result res;
        logic [16:0] span;
        logic [16:0] count;
        t_step       idx;
        int          bitpos;
        res = '0;
        if (!seq_enable) begin
            seq_line = 1'b0;
            seq_step = STEP_FRAME_START;
            seq_wait = '0;
            return res;
        end
        span  = (seq_divider == '0) ? 17'd1 : {1'b0, seq_divider};
        count = {1'b0, seq_wait} + 17'd1;
        if (count < span) begin
            // divider wait: line holds, no frame start
            seq_wait = count[15:0];
        end else begin
            seq_wait = '0;
            idx      = seq_step;
            if (idx == STEP_FRAME_START) begin
                seq_line        = 1'b1;
                seq_word        = frame_word_of(sample);
                res.frame_start = 1'b1;
                idx++;
            end else if (idx == STEP_LEAD || idx == STEP_STOP_END) begin
                idx++;
            end else if (idx == STEP_STOP_LOW) begin
                seq_line = 1'b0;
                idx++;
            end else if (idx == STEP_LAST) begin
                seq_line = 1'b0;
                idx      = STEP_FRAME_START;
            end else begin
                // Even steps always toggle. Odd steps toggle mid-bit for a one
                // while data is sent, and always in the gap after the stop bit.
                if (idx[0]) begin
                    if (idx > STEP_STOP_END) begin
                        seq_line = ~seq_line;
                    end else begin
                        bitpos = int'(idx >> 1) - 1;
                        if (seq_word[bitpos]) seq_line = ~seq_line;
                    end
                end else begin
                    seq_line = ~seq_line;
                end
                idx++;
            end
            seq_step = idx;
        end
        res.ask_level = seq_line;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Tick driver: offer pending samples, predict each transfer as it lands
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) predicted_levels.push_back(step_modulator(drv_sample));
            // Hold the offer until it is taken; only then move to the next one.
            if (!drv_valid || in_if.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    drv_valid  <= 1'b1;
                    drv_sample <= pending_ticks.pop_front();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and sink: check each transfer, stall at random or for a
    // long stretch on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_if.valid && sink_ready) begin
                if (predicted_levels.size() == 0) begin
                    $error("unexpected transfer: ask_level %0b frame_start %0b",
                           out_if.ask_level, out_if.frame_start);
                    fail_count++;
                end else begin
                    owed = predicted_levels.pop_front();
                    if (out_if.ask_level !== owed.ask_level) begin
                        $error("ask_level: expected %0b, actual %0b",
                               owed.ask_level, out_if.ask_level);
                        fail_count++;
                    end
                    if (out_if.frame_start !== owed.frame_start) begin
                        $error("frame_start: expected %0b, actual %0b",
                               owed.frame_start, out_if.frame_start);
                        fail_count++;
                    end
                end
            end
            if (hold_requests != holds_done) begin
                holds_done <= holds_done + 1;
                hold_left  <= LONG_HOLD;
                sink_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ask_power_frame_modulator_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Wait until every tick is offered, taken and answered, then let the
    // pipeline settle so a register write cannot meet a tick in flight.
    task automatic drain();
        while (pending_ticks.size() != 0 || drv_valid || predicted_levels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register transfer; the sequencer copy follows at the same edge.
    task automatic write_register(t_cfg_index idx, t_cfg_data value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLE: begin
                seq_enable = value[0];
                if (!seq_enable) begin
                    seq_line = 1'b0;
                    seq_step = STEP_FRAME_START;
                    seq_wait = '0;
                end
            end
            CFG_TICK_DIVIDER: begin
                seq_divider = value;
                seq_step    = STEP_FRAME_START;
                seq_wait    = '0;
            end
            CFG_POWER_REQUEST: seq_request = value[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Single-bit register value with random junk above bit 0.
    function automatic t_cfg_data flag_word(logic flag);
        return {15'($urandom), flag};
    endfunction

    // Queue random samples: mostly inside the clamp window for code variety,
    // some anywhere in the 17-bit range, some right on the limits.
    task automatic push_ticks(int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                pending_ticks.push_back(t_power_sample'($urandom_range(0, FULL_SCALE + 100)));
            else if (pick < 8)
                pending_ticks.push_back(t_power_sample'($urandom));
            else
                pending_ticks.push_back(
                    t_power_sample'(LIMIT_SAMPLES[$urandom_range(0, $size(LIMIT_SAMPLES) - 1)]));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Disabled ticks straight out of reset: line must stay low.
        pending_ticks.push_back(t_power_sample'(0));
        pending_ticks.push_back(t_power_sample'(65535));
        pending_ticks.push_back(t_power_sample'(-65536));
        drain();

        // Unused register index must leave everything alone.
        write_register(CFG_SPARE, t_cfg_data'($urandom));
        write_register(CFG_ENABLE, flag_word(1'b1));

        // Limit samples: restart the sequence each time so the first tick
        // lands on step 0 and latches that very sample. Alternate a divider
        // of 0 and 1, and flip the request bit.
        foreach (LIMIT_SAMPLES[i]) begin
            write_register(CFG_TICK_DIVIDER, t_cfg_data'(i % 2));
            write_register(CFG_POWER_REQUEST, flag_word(i[1]));
            pending_ticks.push_back(t_power_sample'(LIMIT_SAMPLES[i]));
            pending_ticks.push_back(t_power_sample'(LIMIT_SAMPLES[i]));
            drain();
        end

        // Sender idles about a third of the time; sink idles about half.
        src_idle_pct = 32;
        snk_idle_pct = 53;
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(1));
        write_register(CFG_POWER_REQUEST, flag_word(1'b0));
        push_ticks(150);
        // Hold the sink off while ticks keep coming so the input stalls.
        while (pending_ticks.size() > 75) @(negedge i_clk);
        hold_requests++;
        drain();
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(0));
        write_register(CFG_POWER_REQUEST, flag_word(1'b1));
        push_ticks(150);
        drain();

        // Swap the idle rates.
        src_idle_pct = 53;
        snk_idle_pct = 32;
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(2));
        push_ticks(100);
        drain();
        write_register(CFG_ENABLE, flag_word(1'b0));
        push_ticks(20);
        drain();
        write_register(CFG_ENABLE, flag_word(1'b1));
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(3));
        push_ticks(150);
        drain();
        // Largest divider: the sequencer only counts within this run.
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(16'hFFFF));
        push_ticks(60);
        drain();

        // No idling on either side.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_register(CFG_TICK_DIVIDER, t_cfg_data'(1));
        write_register(CFG_POWER_REQUEST, flag_word(1'($urandom_range(0, 1))));
        push_ticks(100);
        while (pending_ticks.size() > 50) @(negedge i_clk);
        hold_requests++;
        // Pause the sender until everything owed has come back.
        drain();
        push_ticks(100);
        drain();
        write_register(CFG_TICK_DIVIDER, t_cfg_data'($urandom_range(0, 4)));
        write_register(CFG_POWER_REQUEST, flag_word(1'($urandom_range(0, 1))));
        push_ticks(100);
        drain();

        if (fail_count == 0) begin
            $display("ask_power_frame_modulator_top: match");
        end else begin
            $display("ask_power_frame_modulator_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
